FILE: hw/rtl/rx_frame_check_and_classify_defines.svh
// Assertion macros for the checker file of the frame classifier.
`ifndef RX_FRAME_CHECK_AND_CLASSIFY_DEFINES_SVH
`define RX_FRAME_CHECK_AND_CLASSIFY_DEFINES_SVH

// Condition in the same cycle implies the consequence in that cycle.
`define RXFCC_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("frame classifier check failed");

// Condition in one cycle implies the consequence in the next cycle.
`define RXFCC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("frame classifier check failed");

`endif

FILE: hw/rtl/rxfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rxfcc_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED       = 2'd0,
        STATUS_CHECK_MISMATCH = 2'd1,
        STATUS_BAD_LENGTH     = 2'd2
    } frame_status_t;

    typedef enum logic [2:0] {
        KIND_TEST_DATA  = 3'd0,
        KIND_OPEN_FAULT = 3'd1,
        KIND_TEST_END   = 3'd2,
        KIND_OK         = 3'd3,
        KIND_NONE       = 3'd4
    } reply_kind_t;

    // One result beat; frame_status sits in the lowest bits when packed.
    typedef struct packed {
        byte_t         payload_length;
        reply_kind_t   reply_kind;
        frame_status_t frame_status;
    } frame_result_t;

    // One input beat as held in the input register.
    typedef struct packed {
        byte_t rx_byte;
        logic  end_of_frame;
    } rx_beat_t;

    localparam int RESULT_W  = $bits(frame_result_t);
    localparam int TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    localparam int    NAME_COUNT = 4;
    localparam int    NAME_SLOTS = 16;
    localparam byte_t CHAR_COLON = 8'h3A;
    localparam byte_t CHAR_HASH  = 8'h23;
    localparam byte_t CHECK_MSB  = 8'h80;

    // Reply names, padded with zeros; the length check masks the padding.
    localparam byte_t NAME_TEXT [NAME_COUNT][NAME_SLOTS] = '{
        '{"T", "_", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "P", "E", "N", "_", "E", "R", "R",
          "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "E", "S", "T", "_", "O", "V", "E",
          "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{4'd3, 4'd10, 4'd9, 4'd2};

    // The literal frame that is always taken, padded to a power of two.
    localparam byte_t OK_TEXT [4] = '{"O", "K", "#", 8'h00};

endpackage

`default_nettype wire

FILE: hw/rtl/rxfcc_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rxfcc_frame_core #(
    parameter int MAX_FRAME = 128
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire rxfcc_pkg::rx_beat_t     beat,
    output rxfcc_pkg::frame_result_t     result
);

    localparam int LEN_W = $clog2(MAX_FRAME + 2);

    rxfcc_pkg::byte_t held0_reg, held0_next;
    rxfcc_pkg::byte_t held1_reg, held1_next;
    logic [1:0]       held_count_reg, held_count_next;
    rxfcc_pkg::byte_t sum_reg, sum_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       pos_reg, pos_next;
    logic [3:0]       cand_reg, cand_next;
    logic             in_pay_reg, in_pay_next;
    rxfcc_pkg::byte_t pay_cnt_reg, pay_cnt_next;
    logic [1:0]       ok_match_reg, ok_match_next;

    logic             take_body;
    rxfcc_pkg::byte_t body;

    // Advance the frame state by one byte and classify on the last one
    always_comb
    begin
        take_body       = (held_count_reg == 2'd2);
        body            = held0_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        cand_next       = cand_reg;
        in_pay_next     = in_pay_reg;
        pay_cnt_next    = pay_cnt_reg;

        // Byte leaving the two-byte delay joins the body
        if (take_body)
        begin
            sum_next = sum_reg + body;
            if (in_pay_reg)
            begin
                if (pay_cnt_reg != 8'hFF)
                    pay_cnt_next = pay_cnt_reg + 8'd1;
            end
            else if (body == rxfcc_pkg::CHAR_COLON || body == rxfcc_pkg::CHAR_HASH)
            begin
                in_pay_next = 1'b1;
            end
            else
            begin
                for (int k = 0; k < rxfcc_pkg::NAME_COUNT; k++)
                begin
                    if (pos_reg >= rxfcc_pkg::NAME_LEN[k] ||
                        rxfcc_pkg::NAME_TEXT[k][pos_reg] != body)
                        cand_next[k] = 1'b0;
                end
                if (pos_reg != 4'hF)
                    pos_next = pos_reg + 4'd1;
            end
        end

        // Shift the delay line
        held0_next      = held1_reg;
        held1_next      = beat.rx_byte;
        held_count_next = (held_count_reg == 2'd2) ? held_count_reg : held_count_reg + 2'd1;

        // Track the literal short frame
        ok_match_next = ok_match_reg;
        if (len_reg < LEN_W'(3) && ok_match_reg == len_reg[1:0] &&
            beat.rx_byte == rxfcc_pkg::OK_TEXT[len_reg[1:0]])
            ok_match_next = len_reg[1:0] + 2'd1;

        len_next = (len_reg < LEN_W'(MAX_FRAME + 1)) ? len_reg + LEN_W'(1) : len_reg;

        // Classify from the updated state
        result.frame_status   = rxfcc_pkg::STATUS_ACCEPTED;
        result.reply_kind     = rxfcc_pkg::KIND_NONE;
        result.payload_length = 8'd0;
        if (len_next == LEN_W'(3) && ok_match_next == 2'd3)
        begin
            result.reply_kind = rxfcc_pkg::KIND_OK;
        end
        else if (len_next < LEN_W'(2) || len_next > LEN_W'(MAX_FRAME))
        begin
            result.frame_status = rxfcc_pkg::STATUS_BAD_LENGTH;
        end
        else if (held0_next != (sum_next | rxfcc_pkg::CHECK_MSB))
        begin
            result.frame_status = rxfcc_pkg::STATUS_CHECK_MISMATCH;
        end
        else
        begin
            // Lowest-numbered name that matched in full wins
            for (int k = rxfcc_pkg::NAME_COUNT - 1; k >= 0; k--)
            begin
                if (cand_next[k] && rxfcc_pkg::NAME_LEN[k] == pos_next)
                    result.reply_kind = rxfcc_pkg::reply_kind_t'(3'(k));
            end
            result.payload_length = in_pay_next ? pay_cnt_next : 8'd0;
        end
    end

    // Frame state; drop everything after the last byte of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg      <= '0;
            held1_reg      <= '0;
            held_count_reg <= '0;
            sum_reg        <= '0;
            len_reg        <= '0;
            pos_reg        <= '0;
            cand_reg       <= '1;
            in_pay_reg     <= 1'b0;
            pay_cnt_reg    <= '0;
            ok_match_reg   <= '0;
        end
        else if (advance)
        begin
            if (beat.end_of_frame)
            begin
                held0_reg      <= '0;
                held1_reg      <= '0;
                held_count_reg <= '0;
                sum_reg        <= '0;
                len_reg        <= '0;
                pos_reg        <= '0;
                cand_reg       <= '1;
                in_pay_reg     <= 1'b0;
                pay_cnt_reg    <= '0;
                ok_match_reg   <= '0;
            end
            else
            begin
                held0_reg      <= held0_next;
                held1_reg      <= held1_next;
                held_count_reg <= held_count_next;
                sum_reg        <= sum_next;
                len_reg        <= len_next;
                pos_reg        <= pos_next;
                cand_reg       <= cand_next;
                in_pay_reg     <= in_pay_next;
                pay_cnt_reg    <= pay_cnt_next;
                ok_match_reg   <= ok_match_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rx_frame_check_and_classify.sv
// Received-frame checker and reply classifier. Bytes of one text frame enter
// on the s_axis side, the last byte marked by s_axis_tlast; a frame is a body,
// a check byte and a closing byte. For each frame one result beat leaves on
// m_axis from an output register, loaded as its last byte leaves the input
// register: status (accepted, check mismatch, bad length), the reply name that
// the body holds in full before its first ':' or '#', and the payload length
// after that separator. The check passes when the 8-bit sum of the body, with
// bit 7 forced high, equals the check byte; the exact frame "OK#" is always
// accepted. Frames of one byte or of more than MAX_FRAME bytes are flagged.
// The block takes one byte per clock cycle: each byte passes through an input
// register and one pass of logic that updates the running frame state, and
// the result sits in an output register, so input is only held back while a
// finished result waits there and another last byte is ready behind it.
`timescale 1ns / 1ps
`default_nettype none

module rx_frame_check_and_classify #(
    parameter int MAX_FRAME = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                         s_axis_tlast,  // end_of_frame
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [1:0] frame_status, [4:2] reply_kind, [12:5] payload_length, rest zero
    output logic [rxfcc_pkg::TDATA_W-1:0]     m_axis_tdata
);

    logic                     in_valid_reg, in_valid_next;
    rxfcc_pkg::rx_beat_t      in_beat_reg;
    logic                     out_valid_reg, out_valid_next;
    rxfcc_pkg::frame_result_t out_result_reg;
    rxfcc_pkg::frame_result_t core_result;

    logic s_accept;
    logic out_free;
    logic in_advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_advance    = in_valid_reg && (!in_beat_reg.end_of_frame || out_free);
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Hold the input beat until the frame logic takes it
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (in_advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_beat_reg.rx_byte      <= s_axis_tdata;
            in_beat_reg.end_of_frame <= s_axis_tlast;
        end
    end

    rxfcc_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_advance),
        .beat    (in_beat_reg),
        .result  (core_result)
    );

    // Result register: load on a last byte, release on the output beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_advance && in_beat_reg.end_of_frame)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && in_beat_reg.end_of_frame)
            out_result_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rxfcc_pkg::TDATA_W - rxfcc_pkg::RESULT_W){1'b0}}, out_result_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/rxfcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rx_frame_check_and_classify_defines.svh"

module rxfcc_checker (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [rxfcc_pkg::TDATA_W-1:0] m_axis_tdata
);

    rxfcc_pkg::frame_result_t res;
    logic out_stall;
    logic out_reject;
    logic reject_clean;
    logic codes_legal;
    logic pad_zero;

    assign res          = m_axis_tdata[rxfcc_pkg::RESULT_W-1:0];
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_reject   = m_axis_tvalid && res.frame_status != rxfcc_pkg::STATUS_ACCEPTED;
    assign reject_clean = res.reply_kind == rxfcc_pkg::KIND_NONE &&
                          res.payload_length == 8'd0;
    assign codes_legal  = res.frame_status <= rxfcc_pkg::STATUS_BAD_LENGTH &&
                          res.reply_kind <= rxfcc_pkg::KIND_NONE;
    assign pad_zero     = m_axis_tdata[rxfcc_pkg::TDATA_W-1:rxfcc_pkg::RESULT_W] == '0;

    // A stalled result stays put
    `RXFCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // A rejected frame names no reply and no payload
    `RXFCC_ASSERT_NOW(a_reject_clean, clk, rst_n, out_reject, reject_clean)

    // Status and reply codes stay within their defined sets
    `RXFCC_ASSERT_NOW(a_codes_legal, clk, rst_n, m_axis_tvalid, codes_legal)

    // Padding bits of the result beat stay zero
    `RXFCC_ASSERT_NOW(a_pad_zero, clk, rst_n, m_axis_tvalid, pad_zero)

endmodule

bind rx_frame_check_and_classify rxfcc_checker u_rxfcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: bench/frame_result_checker.sv
`timescale 1ns / 1ps

module frame_result_checker #(
    parameter int MAX_FRAME = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  logic                          s_axis_tlast,  // end_of_frame
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] frame_status, [4:2] reply_kind, [12:5] payload_length, rest zero
    input  logic [rxfcc_pkg::TDATA_W-1:0] m_axis_tdata,
    output int                            mismatch_count,
    output int                            results_awaited
);

    // Reply names, in the order of their kind codes
    string reply_word [4] = '{"T_D", {string'("OPEN_"), "ERROR"},
                              {string'("TEST_"), "OVER"}, "OK"};
    rxfcc_pkg::reply_kind_t reply_code [4] = '{rxfcc_pkg::KIND_TEST_DATA,
                                               rxfcc_pkg::KIND_OPEN_FAULT,
                                               rxfcc_pkg::KIND_TEST_END,
                                               rxfcc_pkg::KIND_OK};
    string ok_frame = "OK#";

    // Frame state of the prediction
    logic [7:0] delay_old;
    logic [7:0] delay_new;
    int         delay_fill;
    logic [7:0] body_sum;
    int         byte_count;
    int         name_pos;
    logic [3:0] still_match;
    bit         after_sep;
    int         payload_cnt;
    int         ok_prefix;

    int                       error_total = 0;
    rxfcc_pkg::frame_result_t awaited[$];

    function automatic void clear_frame_state();
        delay_old   = 8'h00;
        delay_new   = 8'h00;
        delay_fill  = 0;
        body_sum    = 8'h00;
        byte_count  = 0;
        name_pos    = 0;
        still_match = 4'hF;
        after_sep   = 1'b0;
        payload_cnt = 0;
        ok_prefix   = 0;
    endfunction

    // Advance the frame state by one byte; return 1 with the result on the last byte
    function automatic bit predict_rx_byte(input logic [7:0] rx, input bit last,
                                           output rxfcc_pkg::frame_result_t res);
        int         idx;
        logic [7:0] leaving;
        bit         found;
        idx = byte_count;
        // Retire the oldest held byte into the body
        if (delay_fill == 2)
        begin
            leaving  = delay_old;
            body_sum = body_sum + leaving;
            if (after_sep)
            begin
                if (payload_cnt < 255)
                    payload_cnt++;
            end
            else if (leaving == rxfcc_pkg::CHAR_COLON || leaving == rxfcc_pkg::CHAR_HASH)
            begin
                after_sep = 1'b1;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                    if (name_pos >= reply_word[k].len() || reply_word[k][name_pos] != leaving)
                        still_match[k] = 1'b0;
                if (name_pos < 15)
                    name_pos++;
            end
        end
        delay_old = delay_new;
        delay_new = rx;
        if (delay_fill < 2)
            delay_fill++;

        if (idx < 3 && ok_prefix == idx && rx == ok_frame[idx])
            ok_prefix = idx + 1;
        if (byte_count < MAX_FRAME + 1)
            byte_count++;

        if (!last)
            return 1'b0;

        res.frame_status   = rxfcc_pkg::STATUS_ACCEPTED;
        res.reply_kind     = rxfcc_pkg::KIND_NONE;
        res.payload_length = 8'd0;
        if (byte_count == 3 && ok_prefix == 3)
        begin
            res.reply_kind = rxfcc_pkg::KIND_OK;
        end
        else if (byte_count < 2 || byte_count > MAX_FRAME)
        begin
            res.frame_status = rxfcc_pkg::STATUS_BAD_LENGTH;
        end
        else if (delay_old != (body_sum | rxfcc_pkg::CHECK_MSB))
        begin
            res.frame_status = rxfcc_pkg::STATUS_CHECK_MISMATCH;
        end
        else
        begin
            found = 1'b0;
            for (int k = 0; k < 4; k++)
                if (!found && still_match[k] && reply_word[k].len() == name_pos)
                begin
                    res.reply_kind = reply_code[k];
                    found          = 1'b1;
                end
            res.payload_length = after_sep ? 8'(payload_cnt) : 8'd0;
        end
        clear_frame_state();
        return 1'b1;
    endfunction

    // Predict on every input beat, compare every result beat with the oldest prediction
    always @(posedge clk)
    begin : watch
        rxfcc_pkg::frame_result_t want;
        rxfcc_pkg::frame_result_t got;
        if (!rst_n)
        begin
            clear_frame_state();
            awaited.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_rx_byte(s_axis_tdata, s_axis_tlast, want))
                    awaited.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[rxfcc_pkg::RESULT_W-1:0];
                if (awaited.size() == 0)
                begin
                    $display("%0t: result beat with none expected, got tdata %h",
                             $time, m_axis_tdata);
                    error_total++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got.frame_status != want.frame_status)
                    begin
                        $display("%0t: frame_status expected %0d, got %0d",
                                 $time, want.frame_status, got.frame_status);
                        error_total++;
                    end
                    if (got.reply_kind != want.reply_kind)
                    begin
                        $display("%0t: reply_kind expected %0d, got %0d",
                                 $time, want.reply_kind, got.reply_kind);
                        error_total++;
                    end
                    if (got.payload_length != want.payload_length)
                    begin
                        $display("%0t: payload_length expected %0d, got %0d",
                                 $time, want.payload_length, got.payload_length);
                        error_total++;
                    end
                    if (m_axis_tdata[rxfcc_pkg::TDATA_W-1:rxfcc_pkg::RESULT_W] != '0)
                    begin
                        $display("%0t: tdata padding expected 0, got %h", $time,
                                 m_axis_tdata[rxfcc_pkg::TDATA_W-1:rxfcc_pkg::RESULT_W]);
                        error_total++;
                    end
                end
            end
        end
        mismatch_count  <= error_total;
        results_awaited <= awaited.size();
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_FRAME   = 128;
    localparam int BYTE_BUDGET = 1150;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = 8'h00;
    logic                          s_axis_tlast  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [rxfcc_pkg::TDATA_W-1:0] m_axis_tdata;
    int                            mismatch_count;
    int                            results_awaited;

    // Idling per phase: no idling, sender gaps, receiver stalls, both
    int gap_by_phase   [4] = '{0, 55, 0, 28};
    int stall_by_phase [4] = '{0, 0, 55, 28};
    int gap_pct   = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    string      reply_word [4] = '{"T_D", {string'("OPEN_"), "ERROR"},
                                   {string'("TEST_"), "OVER"}, "OK"};
    logic [7:0] frame_q[$];

    rx_frame_check_and_classify #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    frame_result_checker #(
        .MAX_FRAME(MAX_FRAME)
    ) result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .results_awaited(results_awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Append the check byte over the body so far, spoilt on request, then the closing byte
    task automatic close_frame(input bit bad_check, input logic [7:0] closing);
        logic [7:0] sum;
        sum = 8'h00;
        foreach (frame_q[i])
            sum = sum + frame_q[i];
        sum = sum | rxfcc_pkg::CHECK_MSB;
        if (bad_check)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
        frame_q.push_back(closing);
    endtask

    // Drive the queued frame beat by beat, marking the last beat
    task automatic send_frame();
        gap_pct   = gap_by_phase[(bytes_sent / 160) % 4];
        stall_pct = stall_by_phase[(bytes_sent / 160) % 4];
        for (int i = 0; i < frame_q.size(); i++)
        begin
            while ($urandom_range(0, 99) < gap_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_q[i];
            s_axis_tlast  <= (i == frame_q.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            bytes_sent++;
        end
        frame_q.delete();
    endtask

    task automatic build_random_frame(input int serial);
        int pick;
        int k;
        int idx;
        int sep;
        pick = $urandom_range(0, 99);
        if (serial == 12 || serial == 40)
        begin
            // Long frames: exactly at the size limit, then one byte over
            push_text(reply_word[0]);
            frame_q.push_back(rxfcc_pkg::CHAR_COLON);
            push_random(serial == 12 ? MAX_FRAME - 6 : MAX_FRAME - 5);
            close_frame(1'b0, rxfcc_pkg::CHAR_HASH);
        end
        else if (pick < 70)
        begin
            // Name (some spoilt or random), optional separator, payload; some spoilt checks
            k = $urandom_range(0, 5);
            if (k < 4)
            begin
                push_text(reply_word[k]);
            end
            else if (k == 4)
            begin
                push_text(reply_word[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1))
                begin
                    frame_q.push_back("S");
                end
                else
                begin
                    idx = $urandom_range(0, frame_q.size() - 1);
                    frame_q[idx] = frame_q[idx] ^ 8'h01;
                end
            end
            else
            begin
                // random upper-case letters and underscores
                repeat ($urandom_range(0, 12))
                    frame_q.push_back($urandom_range(0, 3) == 0 ?
                                      8'h5F : 8'($urandom_range(8'h41, 8'h5A)));
            end
            sep = $urandom_range(0, 9);
            if (sep < 5)
                frame_q.push_back(rxfcc_pkg::CHAR_COLON);
            else if (sep < 8)
                frame_q.push_back(rxfcc_pkg::CHAR_HASH);
            push_random($urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 8));
            close_frame(pick >= 60, $urandom_range(0, 9) == 0 ?
                                    8'($urandom_range(0, 255)) : rxfcc_pkg::CHAR_HASH);
        end
        else if (pick < 76)
        begin
            // The literal acknowledgement and near misses of it
            push_text("OK");
            frame_q.push_back($urandom_range(0, 1) ? rxfcc_pkg::CHAR_HASH
                                                   : 8'($urandom_range(0, 255)));
        end
        else if (pick < 82)
        begin
            push_random($urandom_range(1, 2));
        end
        else
        begin
            push_random($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        int serial;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames
        push_text("OK#");
        send_frame();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q = '{8'h80, 8'h00};
        send_frame();
        frame_q = '{8'h7F, rxfcc_pkg::CHAR_HASH};
        send_frame();
        push_text("OK");
        close_frame(1'b0, rxfcc_pkg::CHAR_HASH);
        send_frame();
        frame_q = '{8'h00, 8'h00};
        close_frame(1'b0, 8'h00);
        send_frame();
        push_text("T_D:");
        frame_q.push_back(8'hFF);
        close_frame(1'b0, rxfcc_pkg::CHAR_HASH);
        send_frame();

        // Random frames
        serial = 0;
        while (bytes_sent < BYTE_BUDGET)
        begin
            build_random_frame(serial);
            send_frame();
            serial++;
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then hold for stray beats
        @(posedge clk);
        while (results_awaited != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
